FILE: hdl/srmm_pkg.sv
`default_nettype none

package srmm_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int FRACTION_BITS = 8;
   localparam int COUNT_WIDTH   = 16;
   localparam int OFFSET_WIDTH  = 11;

   // Accumulator holds the mean with fraction bits; the difference needs one more bit.
   localparam int ACC_WIDTH  = SAMPLE_WIDTH + FRACTION_BITS;
   localparam int DIFF_WIDTH = ACC_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2(DIFF_WIDTH + 1);

   localparam int REQ_DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS       = 4 * SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_ADDR_WIDTH-3:0] REG_OFFSET_CORRECTION = '0;

endpackage

`default_nettype wire

FILE: hdl/sensor_running_min_max_mean.sv
// Each sample transfer starts the radix-2 divider for 25 steps; once it is done, the
// finish state publishes the result as soon as the output register is free.
// The single divider takes one sample at a time, so no new sample is accepted until
// the result is published; the next sample is taken the cycle after that.
// Reset (synchronous, active high) clears min to the largest value, max to
// the smallest, mean and count to zero and the offset register to zero.
`default_nettype none

module sensor_running_min_max_mean
   import srmm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // raw_sample[15:0]
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // corrected_value[15:0], minimum_value[31:16], maximum_value[47:32],
   // mean_value[63:48], samples_seen[79:64]
   output logic      [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'((64'(1) << FRACTION_BITS) - 1);

   state_type                      state_ff, state_in;
   logic signed [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic signed [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff, max_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic                           neg_ff, neg_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]      rsp_data_ff, rsp_data_in;

   logic                           req_xfer;
   logic                           csr_write;
   logic                           csr_hit;
   logic signed [SAMPLE_WIDTH:0]   sum;
   logic signed [SAMPLE_WIDTH-1:0] x_sat;
   logic [COUNT_WIDTH-1:0]         count_next;
   logic signed [DIFF_WIDTH-1:0]   diff;
   logic [DIFF_WIDTH-1:0]          diff_mag;
   logic [DIFF_WIDTH-1:0]          quo_mag;
   logic [DIFF_WIDTH-1:0]          quo_signed;
   logic signed [ACC_WIDTH-1:0]    acc_new;
   logic [ACC_WIDTH-1:0]           acc_biased;
   logic [SAMPLE_WIDTH-1:0]        mean;
   logic                           out_free;
   logic                           div_done;

   assign req_xfer  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit   = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_OFFSET_CORRECTION);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Add the offset, clamp to the sample range, and form the distance from the running mean.
   always_comb begin
      sum = (SAMPLE_WIDTH+1)'($signed(req_tdata[SAMPLE_WIDTH-1:0]))
          + (SAMPLE_WIDTH+1)'(offset_ff);
      if (sum[SAMPLE_WIDTH] != sum[SAMPLE_WIDTH-1]) begin
         x_sat = sum[SAMPLE_WIDTH] ? SMIN : SMAX;
      end else begin
         x_sat = sum[SAMPLE_WIDTH-1:0];
      end
      count_next = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      diff       = DIFF_WIDTH'($signed({x_sat, {FRACTION_BITS{1'b0}}}))
                 - DIFF_WIDTH'(acc_ff);
      diff_mag   = diff[DIFF_WIDTH-1] ? (~diff + 1'b1) : diff;
   end

   srmm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .dividend (diff_mag),
      .divisor  (count_next),
      .quotient (quo_mag),
      .done     (div_done)
   );

   // Apply the sign, update the accumulator, truncate the mean toward zero.
   always_comb begin
      quo_signed = neg_ff ? (~quo_mag + 1'b1) : quo_mag;
      acc_new    = acc_ff + quo_signed[ACC_WIDTH-1:0];
      acc_biased = acc_new[ACC_WIDTH-1] ? (acc_new + ROUND_BIAS) : acc_new;
      mean       = acc_biased[ACC_WIDTH-1:FRACTION_BITS];
   end

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      x_in         = x_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write && csr_hit) begin
         offset_in = csr_pwdata[OFFSET_WIDTH-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_in     = x_sat;
               neg_in   = diff[DIFF_WIDTH-1];
               count_in = count_next;
               if (x_sat < min_ff) begin
                  min_in = x_sat;
               end
               if (x_sat > max_ff) begin
                  max_in = x_sat;
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register can take the result.
            if (out_free) begin
               acc_in       = acc_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_WIDTH'({count_ff, mean, max_ff, min_ff, x_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= '0;
         min_ff       <= SMAX;
         max_ff       <= SMIN;
         acc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_WIDTH'(offset_ff) : '0;

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_DIVIDE))
      else $error("sample transfer did not start a divide");

   a_done_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   a_result_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff[SAMPLE_WIDTH-1:0])
                        >= $signed(rsp_data_ff[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])
                     && $signed(rsp_data_ff[SAMPLE_WIDTH-1:0])
                        <= $signed(rsp_data_ff[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH])))
      else $error("corrected value outside min and max");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (count_ff != '0))
      else $error("divide with a zero sample count");

endmodule

`default_nettype wire

FILE: hdl/srmm_divider.sv
`default_nettype none

module srmm_divider
   import srmm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DIFF_WIDTH-1:0]  dividend,
   input  wire logic [COUNT_WIDTH-1:0] divisor,
   output logic      [DIFF_WIDTH-1:0]  quotient,
   output logic                        done
);

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(DIFF_WIDTH - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [DIFF_WIDTH-1:0]  quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] dvs_ff, dvs_in;

   logic [COUNT_WIDTH:0]   rem_shift;
   logic [COUNT_WIDTH:0]   trial;
   logic                   fits;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIFF_WIDTH-1]};
      trial     = rem_shift - {1'b0, dvs_ff};
      fits      = (rem_shift >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
         quo_in  = {quo_ff[DIFF_WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import srmm_pkg::*;

   localparam int     CLOCK_PERIOD = 20;
   localparam int     RESET_CYCLES = 7;
   localparam longint CYCLE_LIMIT  = 6_000_000;
   localparam int     LONG_HOLD    = 400;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     PHASE_ITEMS  = 200;
   localparam int     STEADY_ITEMS = 60;
   localparam int     PRINT_LIMIT  = 40;

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_WIDTH - 1));
   localparam longint SCALE      = longint'(1) <<< FRACTION_BITS;
   localparam int     OFFSET_MAX = 1000;
   localparam int     OFFSET_MIN = -1000;

   // register index 0 sits at byte address 0; the next word has no register
   localparam logic [CSR_ADDR_WIDTH-1:0] OFFSET_ADDR = {REG_OFFSET_CORRECTION, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] UNUSED_ADDR = {~REG_OFFSET_CORRECTION, 2'b00};

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_MOSTLY
   } ready_mode_type;

   // same layout as rsp_tdata, highest field first
   typedef struct packed {
      logic        [COUNT_WIDTH-1:0]  samples_seen;
      logic signed [SAMPLE_WIDTH-1:0] mean_value;
      logic signed [SAMPLE_WIDTH-1:0] maximum_value;
      logic signed [SAMPLE_WIDTH-1:0] minimum_value;
      logic signed [SAMPLE_WIDTH-1:0] corrected_value;
   } stats_type;

   typedef struct {
      logic [SAMPLE_WIDTH-1:0] raw;
      bit                      wait_idle;
   } sample_item_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic [REQ_DATA_WIDTH-1:0] req_tdata   = '0;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   sensor_running_min_max_mean dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // predictor state
   logic signed [OFFSET_WIDTH-1:0] offset_setting = '0;
   longint                         track_min      = SAMPLE_MAX;
   longint                         track_max      = SAMPLE_MIN;
   longint                         mean_acc       = 0;
   logic        [COUNT_WIDTH-1:0]  sample_tally   = '0;

   sample_item_type pending_samples[$];
   stats_type       expected_stats[$];

   int     error_count    = 0;
   int     accepted_count = 0;
   int     results_seen   = 0;
   int     offset_writes  = 0;
   longint cycle_count    = 0;
   bit     steady_feed    = 1'b0;
   bit     hold_toggle    = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
   endtask

   function automatic stats_type advance_statistics(input logic signed [SAMPLE_WIDTH-1:0] raw);
      longint    value;
      longint    diff;
      stats_type r;
      value = longint'(raw) + longint'(offset_setting);
      if (value > SAMPLE_MAX) value = SAMPLE_MAX;
      if (value < SAMPLE_MIN) value = SAMPLE_MIN;
      if (value < track_min) track_min = value;
      if (value > track_max) track_max = value;
      if (sample_tally != '1) sample_tally++;
      // division truncates toward zero, as the block's divider does
      diff     = value * SCALE - mean_acc;
      mean_acc = mean_acc + diff / longint'(sample_tally);
      r.corrected_value = SAMPLE_WIDTH'(value);
      r.minimum_value   = SAMPLE_WIDTH'(track_min);
      r.maximum_value   = SAMPLE_WIDTH'(track_max);
      r.mean_value      = SAMPLE_WIDTH'(mean_acc / SCALE);
      r.samples_seen    = sample_tally;
      return r;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] draw_sample();
      case ($urandom_range(0, 4))
         0:       return SAMPLE_WIDTH'($urandom);
         1:       return SAMPLE_WIDTH'(int'($urandom_range(0, 800)) - 400);
         2:       return SAMPLE_WIDTH'(32767 - int'($urandom_range(0, 1500)));
         3:       return SAMPLE_WIDTH'(-32768 + int'($urandom_range(0, 1500)));
         default: return SAMPLE_WIDTH'(int'($urandom_range(0, 600)) + 150);
      endcase
   endfunction

   task automatic queue_sample(input logic [SAMPLE_WIDTH-1:0] raw, input bit wait_idle);
      sample_item_type item;
      item.raw       = raw;
      item.wait_idle = wait_idle;
      pending_samples.push_back(item);
   endtask

   // call right after a rising edge
   task automatic wait_until_idle();
      while (pending_samples.size() != 0 || req_tvalid || expected_stats.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == OFFSET_ADDR) begin
         offset_setting = data[OFFSET_WIDTH-1:0];
         offset_writes++;
      end
   endtask

   task automatic check_offset_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= OFFSET_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[OFFSET_WIDTH-1:0] !== offset_setting)
         report_mismatch("offset readback", 32'(csr_prdata[OFFSET_WIDTH-1:0]),
                         32'(offset_setting));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_offset(input int value);
      logic signed [OFFSET_WIDTH-1:0] v;
      v = OFFSET_WIDTH'(value);
      csr_write(OFFSET_ADDR, {{(CSR_DATA_WIDTH - OFFSET_WIDTH){v[OFFSET_WIDTH-1]}}, v});
      check_offset_readback();
   endtask

   // sample driver: bursts of random length with random gaps
   int burst_left = 4;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_samples
      sample_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_stats.push_back(advance_statistics(req_tdata[SAMPLE_WIDTH-1:0]));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 && !steady_feed) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0 &&
                         !(pending_samples[0].wait_idle && expected_stats.size() != 0)) begin
               item = pending_samples.pop_front();
               req_tdata  <= REQ_DATA_WIDTH'(item.raw);
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver: own stall pattern plus an occasional long hold-off
   ready_mode_type ready_mode   = READY_ALWAYS;
   int             pattern_left = 0;
   int             hold_left    = 0;
   bit             hold_seen    = 1'b0;

   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 96);
            ready_mode   = ready_mode_type'($urandom_range(0, 3));
         end else begin
            pattern_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady_feed) begin
            rsp_tready <= 1'b1;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      stats_type got;
      stats_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         results_seen++;
         if (expected_stats.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(got.corrected_value), 32'h0);
         end else begin
            want = expected_stats.pop_front();
            if (got.corrected_value !== want.corrected_value)
               report_mismatch("corrected_value", 32'(got.corrected_value),
                               32'(want.corrected_value));
            if (got.minimum_value !== want.minimum_value)
               report_mismatch("minimum_value", 32'(got.minimum_value),
                               32'(want.minimum_value));
            if (got.maximum_value !== want.maximum_value)
               report_mismatch("maximum_value", 32'(got.maximum_value),
                               32'(want.maximum_value));
            if (got.mean_value !== want.mean_value)
               report_mismatch("mean_value", 32'(got.mean_value), 32'(want.mean_value));
            if (got.samples_seen !== want.samples_seen)
               report_mismatch("samples_seen", 32'(got.samples_seen), 32'(want.samples_seen));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_stats.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : run_test
      logic [SAMPLE_WIDTH-1:0] reset_corners[] = '{
         16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h5555, 16'haaaa,
         16'd250, -16'sd250
      };
      logic [SAMPLE_WIDTH-1:0] high_corners[] = '{
         16'h7fff, 16'd32000, 16'd31767, 16'd31768, 16'h8000
      };
      logic [SAMPLE_WIDTH-1:0] low_corners[] = '{
         16'h8000, -16'sd31768, -16'sd31769, -16'sd31767, 16'h7fff
      };
      int phase_offsets[6];
      int fill_count;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // offset at its reset value: field extremes and alternating bit patterns
      check_offset_readback();
      foreach (reset_corners[i]) queue_sample(reset_corners[i], 1'b0);
      wait_until_idle();

      // largest offset pushes the top samples into saturation
      set_offset(OFFSET_MAX);
      foreach (high_corners[i]) queue_sample(high_corners[i], 1'b0);
      wait_until_idle();

      // a write to the empty register slot must leave the offset alone
      csr_write(UNUSED_ADDR, $urandom);
      check_offset_readback();
      queue_sample(16'h7fff, 1'b0);
      queue_sample(16'h0000, 1'b0);
      wait_until_idle();

      set_offset(OFFSET_MIN);
      foreach (low_corners[i]) queue_sample(low_corners[i], 1'b0);
      wait_until_idle();

      phase_offsets = '{0, OFFSET_MAX, OFFSET_MIN, 0, 0, 0};
      for (int p = 3; p < 6; p++)
         phase_offsets[p] = int'($urandom_range(0, OFFSET_MAX - OFFSET_MIN)) + OFFSET_MIN;

      for (int p = 0; p < 6; p++) begin
         set_offset(phase_offsets[p]);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_sample(draw_sample(), (p == 4) && (i % 40 == 39));
         // stall the result side while the sender keeps offering
         if (p == 2) hold_toggle <= ~hold_toggle;
         @(posedge clock);
         wait_until_idle();
      end

      // stream back to back with the receiver always ready
      set_offset(int'($urandom_range(0, OFFSET_MAX - OFFSET_MIN)) + OFFSET_MIN);
      steady_feed <= 1'b1;
      fill_count = STEADY_ITEMS;
      for (int i = 0; i < fill_count; i++) queue_sample(draw_sample(), 1'b0);
      @(posedge clock);
      wait_until_idle();
      steady_feed <= 1'b0;

      // random traffic again at both offset extremes
      set_offset(OFFSET_MIN);
      for (int i = 0; i < 40; i++) queue_sample(draw_sample(), 1'b0);
      wait_until_idle();
      set_offset(OFFSET_MAX);
      for (int i = 0; i < 20; i++) queue_sample(draw_sample(), 1'b0);
      wait_until_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d samples, %0d results and %0d offset writes,",
               accepted_count, results_seen, offset_writes);
      $display("with saturated sums, a long result stall, idle waits and a steady stretch.");
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/srmm_pkg.sv
hdl/srmm_divider.sv
hdl/sensor_running_min_max_mean.sv
tb/testbench.sv
